// File: rtl/weight_normalize_threshold_macros.svh
// Assertion macros shared by the weight normalize and threshold block.
`ifndef WEIGHT_NORMALIZE_THRESHOLD_MACROS_SVH
`define WEIGHT_NORMALIZE_THRESHOLD_MACROS_SVH
`ifndef SYNTHESIS
`define WNT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("wnt check failed");
`define WNT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wnt implication failed");
`define WNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wnt sequence failed");
`else
`define WNT_ASSERT(lbl, clk, rst_n, prop)
`define WNT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/wnt_pkg.sv
// Types and codes for the weight normalize and threshold block.
package wnt_pkg;

	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_NORMALIZE_ENABLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ADD_ENABLE       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ADD_THRESHOLD    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_REMOVE_ENABLE    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_REMOVE_THRESHOLD = 3'd4;

	localparam logic [1:0] OP_SCAN_START = 2'd0;
	localparam logic [1:0] OP_SCAN       = 2'd1;
	localparam logic [1:0] OP_APPLY      = 2'd2;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_UPDATE = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_ADD    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} wnt_state_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic step;
		logic finish;
	} wnt_cmd_t;

	typedef struct packed {
		logic div_needed;
		logic out_free;
	} wnt_stat_t;

endpackage

// File: rtl/weight_normalize_threshold.sv
// Scan, scan-start and unused-opcode items: one per cycle while no apply item is in progress, no result.
// Apply item: after accept the controller runs setup (ST_PREP), then the restoring divider (ST_DIV,
// one quotient bit per cycle) when normalizing needs it, then ST_DONE, where the result loads and out_valid rises.
// Input stalls from accept until the result loads, also while a waiting result is stalled:
// a new item is taken only once the last apply item is through.
// Reset clears configuration, min and max to zero and empties the output register.
module weight_normalize_threshold
	import wnt_pkg::*;
#(
	parameter int FRAC_BITS   = 16,
	parameter int WEIGHT_BITS = 24,
	parameter int INDEX_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic signed [WEIGHT_BITS-1:0] weight_in,
	input  logic                          in_group,
	input  logic [INDEX_BITS-1:0]         vertex_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    action,
	output logic [FRAC_BITS:0]            weight_out,
	output logic [INDEX_BITS-1:0]         vertex_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [FRAC_BITS:0]            cfg_data
);

	logic              normalize_enable_q, add_enable_q, remove_enable_q;
	logic [FRAC_BITS:0] add_threshold_q, remove_threshold_q;
	wnt_cmd_t          cmd;
	wnt_stat_t         stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normalize_enable_q <= 1'b0;
			add_enable_q       <= 1'b0;
			add_threshold_q    <= '0;
			remove_enable_q    <= 1'b0;
			remove_threshold_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NORMALIZE_ENABLE: normalize_enable_q <= cfg_data[0];
				REG_ADD_ENABLE:       add_enable_q       <= cfg_data[0];
				REG_ADD_THRESHOLD:    add_threshold_q    <= cfg_data;
				REG_REMOVE_ENABLE:    remove_enable_q    <= cfg_data[0];
				REG_REMOVE_THRESHOLD: remove_threshold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wnt_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.opcode  (opcode),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	wnt_dp #(
		.FRAC_BITS  (FRAC_BITS),
		.WEIGHT_BITS(WEIGHT_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (opcode),
		.weight_in       (weight_in),
		.in_group        (in_group),
		.vertex_index    (vertex_index),
		.normalize_enable(normalize_enable_q),
		.add_enable      (add_enable_q),
		.add_threshold   (add_threshold_q),
		.remove_enable   (remove_enable_q),
		.remove_threshold(remove_threshold_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.action          (action),
		.weight_out      (weight_out),
		.vertex_out      (vertex_out)
	);

endmodule

// File: rtl/wnt_ctrl.sv
// Controller: sequences accept, setup, divider steps and result load.
`include "weight_normalize_threshold_macros.svh"
module wnt_ctrl
	import wnt_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] opcode,
	output logic       in_stall,
	input  wnt_stat_t  stat,
	output wnt_cmd_t   cmd
);

	localparam int CNT_W = $clog2(FRAC_BITS);

	wnt_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic div_last;

	assign div_last = (cnt_q == CNT_W'(FRAC_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && opcode == OP_APPLY) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.div_needed ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`WNT_ASSERT_NEXT(a_apply_enters_prep, clk, arst_n, in_valid && !in_stall && opcode == OP_APPLY, state_q == ST_PREP)
	`WNT_ASSERT_NEXT(a_div_runs_full, clk, arst_n, state_q == ST_DIV && !div_last, state_q == ST_DIV)
	`WNT_ASSERT_NEXT(a_done_releases, clk, arst_n, state_q == ST_DONE && stat.out_free, state_q == ST_IDLE && !in_stall)

endmodule

// File: rtl/wnt_dp.sv
// Datapath: min/max tracking, clamp, restoring divider, decision and output register.
`include "weight_normalize_threshold_macros.svh"
module wnt_dp
	import wnt_pkg::*;
#(
	parameter int FRAC_BITS   = 16,
	parameter int WEIGHT_BITS = 24,
	parameter int INDEX_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wnt_cmd_t                      cmd,
	output wnt_stat_t                     stat,
	input  logic [1:0]                    opcode,
	input  logic signed [WEIGHT_BITS-1:0] weight_in,
	input  logic                          in_group,
	input  logic [INDEX_BITS-1:0]         vertex_index,
	input  logic                          normalize_enable,
	input  logic                          add_enable,
	input  logic [FRAC_BITS:0]            add_threshold,
	input  logic                          remove_enable,
	input  logic [FRAC_BITS:0]            remove_threshold,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    action,
	output logic [FRAC_BITS:0]            weight_out,
	output logic [INDEX_BITS-1:0]         vertex_out
);

	localparam int WB = WEIGHT_BITS;
	localparam int FB = FRAC_BITS;
	localparam int CW = (WB > FB + 2) ? WB : FB + 2;
	localparam logic [FB:0] ONE_W = (FB + 1)'(1) << FB;

	logic signed [WB-1:0] min_q, max_q, w_q;
	logic                 group_q;
	logic [INDEX_BITS-1:0] vtx_q;
	logic [WB-1:0]        rem_q, den_q;
	logic [FB:0]          wf_q;

	logic                 out_valid_q;
	logic [1:0]           action_q;
	logic [FB:0]          wf_out_q;
	logic [INDEX_BITS-1:0] vtx_out_q;

	logic signed [WB:0]   diff_range, diff_w;
	logic signed [CW-1:0] w_x, one_x;
	logic                 range_pos, use_norm;
	logic [FB:0]          wf_clamp, wf_pre;
	logic [WB:0]          shifted, sub;
	logic                 take_bit;
	logic [1:0]           act_d;

	assign diff_range = {max_q[WB-1], max_q} - {min_q[WB-1], min_q};
	assign diff_w     = {w_q[WB-1], w_q} - {min_q[WB-1], min_q};
	assign range_pos  = !diff_range[WB] && (diff_range != '0);
	assign use_norm   = normalize_enable && range_pos;

	assign w_x   = CW'(w_q);
	assign one_x = CW'(ONE_W);

	always_comb begin
		if (w_x < 0) begin
			wf_clamp = '0;
		end else if (w_x > one_x) begin
			wf_clamp = ONE_W;
		end else begin
			wf_clamp = w_x[FB:0];
		end
	end

	always_comb begin
		stat.out_free   = !out_valid_q || !out_stall;
		stat.div_needed = 1'b0;
		if (!use_norm) begin
			wf_pre = wf_clamp;
		end else if (w_q <= min_q) begin
			wf_pre = '0;
		end else if (w_q >= max_q) begin
			wf_pre = ONE_W;
		end else begin
			wf_pre          = '0;
			stat.div_needed = 1'b1;
		end
	end

	// one quotient bit per step; remainder stays below the divisor
	assign shifted  = {rem_q, 1'b0};
	assign take_bit = shifted >= {1'b0, den_q};
	assign sub      = shifted - {1'b0, den_q};

	always_comb begin
		if (group_q) begin
			act_d = (remove_enable && wf_q <= remove_threshold) ? ACT_REMOVE : ACT_UPDATE;
		end else begin
			act_d = (add_enable && wf_q >= add_threshold) ? ACT_ADD : ACT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				case (opcode)
					OP_SCAN_START: begin
						min_q <= weight_in;
						max_q <= weight_in;
					end
					OP_SCAN: begin
						if (weight_in < min_q) begin
							min_q <= weight_in;
						end
						if (weight_in > max_q) begin
							max_q <= weight_in;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			w_q     <= weight_in;
			group_q <= in_group;
			vtx_q   <= vertex_index;
		end
		if (cmd.prep) begin
			wf_q  <= wf_pre;
			rem_q <= diff_w[WB-1:0];
			den_q <= diff_range[WB-1:0];
		end else if (cmd.step) begin
			rem_q <= take_bit ? sub[WB-1:0] : shifted[WB-1:0];
			wf_q  <= {wf_q[FB-1:0], take_bit};
		end
		if (cmd.finish) begin
			action_q  <= act_d;
			wf_out_q  <= wf_q;
			vtx_out_q <= vtx_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign weight_out = wf_out_q;
	assign vertex_out = vtx_out_q;

	`WNT_ASSERT_IMP(a_rem_below_den, clk, arst_n, cmd.step, rem_q < den_q)
	`WNT_ASSERT_IMP(a_weight_in_unit, clk, arst_n, out_valid_q, wf_out_q <= ONE_W)

endmodule

// File: test/tb_weight_normalize_threshold.sv
// Self-checking testbench for weight_normalize_threshold: directed corner cases, then random scan/apply traffic.
module tb_weight_normalize_threshold;
	import wnt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 24;
	localparam int INDEX_BITS  = 16;
	localparam longint ONE_FIX = longint'(1) << FRAC_BITS;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_PAD   = FRAC_BITS + 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1200;

	typedef struct packed {
		logic [1:0]            action;
		logic [FRAC_BITS:0]    weight;
		logic [INDEX_BITS-1:0] vertex;
	} decision_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    opcode;
	logic signed [WEIGHT_BITS-1:0] weight_in;
	logic                          in_group;
	logic [INDEX_BITS-1:0]         vertex_index;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    action;
	logic [FRAC_BITS:0]            weight_out;
	logic [INDEX_BITS-1:0]         vertex_out;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_BITS-1:0]       cfg_index;
	logic [FRAC_BITS:0]            cfg_data;

	// predictor copy of configuration and scan state
	logic                          norm_en = 1'b0;
	logic                          add_en = 1'b0;
	logic [FRAC_BITS:0]            add_thr = '0;
	logic                          rem_en = 1'b0;
	logic [FRAC_BITS:0]            rem_thr = '0;
	logic signed [WEIGHT_BITS-1:0] scan_min = '0;
	logic signed [WEIGHT_BITS-1:0] scan_max = '0;

	decision_t pending_decisions[$];

	int  error_count = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  reg_writes = 0;
	int  cycle_count = 0;
	int  stall_run = 0;
	bit  gap_enable = 1'b1;
	bit  stall_enable = 1'b1;

	weight_normalize_threshold #(
		.FRAC_BITS(FRAC_BITS),
		.WEIGHT_BITS(WEIGHT_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.weight_in(weight_in),
		.in_group(in_group),
		.vertex_index(vertex_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.weight_out(weight_out),
		.vertex_out(vertex_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_decisions.size());
		$display("Test completed with failures");
		$finish;
	end

	function automatic decision_t predict_decision(logic signed [WEIGHT_BITS-1:0] w,
		logic member, logic [INDEX_BITS-1:0] vtx);
		longint wv;
		longint lo;
		longint hi;
		longint span;
		longint scaled;
		decision_t d;
		wv = w;
		lo = scan_min;
		hi = scan_max;
		span = hi - lo;
		// normalize disabled or a zero or negative range falls back to a plain clamp
		if (!norm_en || span <= 0) begin
			scaled = (wv < 0) ? 0 : ((wv > ONE_FIX) ? ONE_FIX : wv);
		end else if (wv <= lo) begin
			scaled = 0;
		end else if (wv >= hi) begin
			scaled = ONE_FIX;
		end else begin
			scaled = ((wv - lo) << FRAC_BITS) / span;
		end
		d.weight = scaled[FRAC_BITS:0];
		if (member) begin
			d.action = (rem_en && d.weight <= rem_thr) ? ACT_REMOVE : ACT_UPDATE;
		end else begin
			d.action = (add_en && d.weight >= add_thr) ? ACT_ADD : ACT_NONE;
		end
		d.vertex = vtx;
		return d;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// track accepted config writes and items, check accepted results
	always @(posedge clk) begin
		decision_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NORMALIZE_ENABLE: norm_en = cfg_data[0];
					REG_ADD_ENABLE:       add_en = cfg_data[0];
					REG_ADD_THRESHOLD:    add_thr = cfg_data;
					REG_REMOVE_ENABLE:    rem_en = cfg_data[0];
					REG_REMOVE_THRESHOLD: rem_thr = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_decisions.size() == 0) begin
					report_mismatch("result with nothing pending, vertex", vertex_out, -1);
				end else begin
					want = pending_decisions.pop_front();
					results_checked++;
					if (action !== want.action)
						report_mismatch($sformatf("action v%0d", want.vertex), action, want.action);
					if (weight_out !== want.weight)
						report_mismatch($sformatf("weight v%0d", want.vertex), weight_out,
							want.weight);
					if (vertex_out !== want.vertex)
						report_mismatch("vertex", vertex_out, want.vertex);
				end
			end
			if (in_valid && !in_stall) begin
				case (opcode)
					OP_SCAN_START: begin
						scan_min = weight_in;
						scan_max = weight_in;
					end
					OP_SCAN: begin
						if (weight_in < scan_min)
							scan_min = weight_in;
						if (weight_in > scan_max)
							scan_max = weight_in;
					end
					OP_APPLY: pending_decisions.push_back(
						predict_decision(weight_in, in_group, vertex_index));
					default: ;
				endcase
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_idle_len();
		if ($urandom_range(99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
			out_stall = 1'b1;
		end else if (stall_enable && $urandom_range(99) < 25) begin
			stall_run = pick_idle_len() - 1;
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input logic [1:0] op, input logic signed [WEIGHT_BITS-1:0] w,
		input logic grp, input logic [INDEX_BITS-1:0] vtx);
		int gap;
		in_valid = 1'b1;
		opcode = op;
		weight_in = w;
		in_group = grp;
		vertex_index = vtx;
		do @(posedge clk); while (in_stall);
		if (op != OP_UNUSED)
			items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
		gap = (gap_enable && $urandom_range(99) >= 60) ? pick_idle_len() : 0;
		repeat (gap) @(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_decisions.size() != 0)
			@(negedge clk);
		// a scan item may still be in flight without any result pending
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [FRAC_BITS:0] data);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_settings(input logic norm, input logic add_on,
		input logic [FRAC_BITS:0] add_level, input logic rem_on,
		input logic [FRAC_BITS:0] rem_level);
		write_reg(REG_NORMALIZE_ENABLE, {{FRAC_BITS{1'b0}}, norm});
		write_reg(REG_ADD_ENABLE, {{FRAC_BITS{1'b0}}, add_on});
		write_reg(REG_ADD_THRESHOLD, add_level);
		write_reg(REG_REMOVE_ENABLE, {{FRAC_BITS{1'b0}}, rem_on});
		write_reg(REG_REMOVE_THRESHOLD, rem_level);
	endtask

	function automatic logic [FRAC_BITS:0] random_threshold();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return ONE_FIX[FRAC_BITS:0];
		if (r < 35)
			return (FRAC_BITS + 1)'($urandom_range(65537, 131071));
		return (FRAC_BITS + 1)'($urandom_range(65536));
	endfunction

	function automatic logic signed [WEIGHT_BITS-1:0] random_weight(int style);
		case (style)
			0: return WEIGHT_BITS'($urandom());
			1: return WEIGHT_BITS'($urandom_range(262144) - 131072);
			2: return WEIGHT_BITS'($urandom_range(65536));
			default: begin
				case ($urandom_range(3))
					0: return {1'b1, {(WEIGHT_BITS-1){1'b0}}};
					1: return {1'b0, {(WEIGHT_BITS-1){1'b1}}};
					2: return '0;
					default: return WEIGHT_BITS'(ONE_FIX);
				endcase
			end
		endcase
	endfunction

	// scan-start, scans, then applies over the same weights
	task automatic send_weight_pass(input bit drain_each);
		logic signed [WEIGHT_BITS-1:0] weights[8];
		int n;
		int style;
		n = $urandom_range(1, 8);
		style = $urandom_range(3);
		for (int i = 0; i < n; i++)
			weights[i] = ($urandom_range(9) == 0) ? random_weight(0) : random_weight(style);
		for (int i = 0; i < n; i++)
			send_item((i == 0) ? OP_SCAN_START : OP_SCAN, weights[i], 1'($urandom_range(1)),
				INDEX_BITS'($urandom_range(65535)));
		for (int i = 0; i < n; i++) begin
			send_item(OP_APPLY, weights[$urandom_range(n - 1)], 1'($urandom_range(1)),
				INDEX_BITS'($urandom_range(65535)));
			if (drain_each)
				wait_drained();
		end
	endtask

	task automatic test_reset_state();
		// all registers zero, min and max zero: plain clamp, no add or remove
		send_item(OP_APPLY, 24'sd0, 1'b0, 16'd0);
		send_item(OP_APPLY, {1'b1, 23'd0}, 1'b1, 16'hFFFF);
		send_item(OP_APPLY, {1'b0, {23{1'b1}}}, 1'b0, 16'h5555);
		send_item(OP_APPLY, 24'sd65536, 1'b1, 16'hAAAA);
		send_item(OP_APPLY, 24'sd65537, 1'b0, 16'd1);
		send_item(OP_APPLY, -24'sd1, 1'b1, 16'd2);
	endtask

	task automatic test_thresholds();
		write_settings(1'b0, 1'b1, 17'd0, 1'b1, 17'd65536);
		send_item(OP_APPLY, 24'sd0, 1'b0, 16'd10);
		send_item(OP_APPLY, 24'sd65536, 1'b1, 16'd11);
		write_settings(1'b0, 1'b1, 17'd65536, 1'b1, 17'd0);
		send_item(OP_APPLY, 24'sd65536, 1'b0, 16'd12);
		send_item(OP_APPLY, 24'sd65535, 1'b0, 16'd13);
		send_item(OP_APPLY, 24'sd0, 1'b1, 16'd14);
		send_item(OP_APPLY, 24'sd1, 1'b1, 16'd15);
		// thresholds above 1.0 can never be reached by an add
		write_settings(1'b0, 1'b1, 17'h1FFFF, 1'b1, 17'h1FFFF);
		send_item(OP_APPLY, 24'sd65536, 1'b0, 16'd16);
		send_item(OP_APPLY, 24'sd65536, 1'b1, 16'd17);
	endtask

	task automatic test_normalize();
		write_settings(1'b1, 1'b1, 17'd32768, 1'b1, 17'd16384);
		// nothing scanned since reset: zero range
		send_item(OP_APPLY, 24'sd40000, 1'b0, 16'd20);
		send_item(OP_SCAN_START, -24'sd1000, 1'b0, 16'd0);
		send_item(OP_SCAN, 24'sd5000, 1'b0, 16'd0);
		send_item(OP_SCAN, -24'sd3000, 1'b1, 16'd0);
		send_item(OP_SCAN, 24'sd3, 1'b0, 16'd0);
		send_item(OP_APPLY, -24'sd3000, 1'b1, 16'd21);
		send_item(OP_APPLY, 24'sd5000, 1'b0, 16'd22);
		send_item(OP_APPLY, {1'b1, 23'd0}, 1'b0, 16'd23);
		send_item(OP_APPLY, 24'sd1000, 1'b1, 16'd24);
		// unused opcode must not widen the range
		send_item(OP_UNUSED, {1'b0, {23{1'b1}}}, 1'b1, 16'hFFFF);
		send_item(OP_APPLY, 24'sd4999, 1'b0, 16'd25);
		send_item(OP_SCAN_START, 24'sd777, 1'b0, 16'd0);
		send_item(OP_APPLY, 24'sd100000, 1'b1, 16'd26);
	endtask

	task automatic test_drain_pressure();
		write_settings(1'b1, 1'b1, random_threshold(), 1'b1, random_threshold());
		repeat (3) send_weight_pass(1'b1);
	endtask

	task automatic test_random_traffic();
		int start_count;
		int phase;
		int phase_end;
		start_count = items_sent;
		phase = 0;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			write_settings(1'($urandom_range(1)), 1'($urandom_range(1)), random_threshold(),
				1'($urandom_range(1)), random_threshold());
			gap_enable = (phase % 3) != 0;
			stall_enable = (phase % 3) != 1;
			phase_end = items_sent + 150;
			while (items_sent < phase_end) begin
				if ($urandom_range(9) == 0)
					send_item(2'($urandom_range(3)), random_weight(0), 1'($urandom_range(1)),
						INDEX_BITS'($urandom_range(65535)));
				else
					send_weight_pass(1'b0);
			end
			phase++;
		end
		gap_enable = 1'b1;
		stall_enable = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_SCAN_START;
		weight_in = '0;
		in_group = 1'b0;
		vertex_index = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_NORMALIZE_ENABLE;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_reset_state();
		test_thresholds();
		test_normalize();
		test_drain_pressure();
		test_random_traffic();

		wait_drained();
		if (pending_decisions.size() != 0)
			report_mismatch("results never delivered", 0, pending_decisions.size());
		$display("Sent %0d scan/apply items, checked %0d decisions, %0d register writes",
			items_sent, results_checked, reg_writes);
		$display("Mismatches: %0d", error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
